// ===== design/cvra_pkg.sv =====
// shared types and constants of the calibration view robust average
`timescale 1ns / 1ps

package cvra_pkg;

	localparam int SAMPLE_FIELDS    = 4;
	localparam int SAMPLES_PER_LOOK = 4;
	localparam int SAMPLE_W         = 16;
	localparam int CNT_W            = 3;
	localparam int SUM_W            = 18;
	localparam int CFG_IDX_W        = 3;
	localparam int IN_DATA_W        = SAMPLE_FIELDS * SAMPLE_W;
	localparam int OUT_DATA_W       = 24;

	// floor(x / 3) = (x * ceil(2^19 / 3)) >> 19 for every 18-bit x
	localparam int DIV3_SHIFT = 19;
	localparam logic [SUM_W-1:0] DIV3_MUL = SUM_W'(174763);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPACE_LOW  = 3'd0,
		REG_SPACE_HIGH = 3'd1,
		REG_BB_LOW     = 3'd2,
		REG_BB_HIGH    = 3'd3,
		REG_DEV_LIMIT  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] space_low;
		logic [SAMPLE_W-1:0] space_high;
		logic [SAMPLE_W-1:0] bb_low;
		logic [SAMPLE_W-1:0] bb_high;
		logic [SAMPLE_W-1:0] dev_limit;
	} limits_t;

endpackage

// ===== design/cvra_cfg.sv =====
// configuration register file: view limits and deviation limit
`timescale 1ns / 1ps

module cvra_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cvra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cvra_pkg::SAMPLE_W-1:0]  cfg_data,
	output cvra_pkg::limits_t              limits
);
	import cvra_pkg::*;

	limits_t lim_q;

	assign cfg_ready = 1'b1;
	assign limits    = lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.space_low  <= '0;
			lim_q.space_high <= '1;
			lim_q.bb_low     <= '0;
			lim_q.bb_high    <= '1;
			lim_q.dev_limit  <= '1;
		end else if (cfg_valid) begin
			// indexes past the list are dropped
			unique case (cfg_reg_t'(cfg_index))
				REG_SPACE_LOW:  lim_q.space_low  <= cfg_data;
				REG_SPACE_HIGH: lim_q.space_high <= cfg_data;
				REG_BB_LOW:     lim_q.bb_low     <= cfg_data;
				REG_BB_HIGH:    lim_q.bb_high    <= cfg_data;
				REG_DEV_LIMIT:  lim_q.dev_limit  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/cvra_div.sv =====
// truncating divide of a sample sum by a count of zero to four
`timescale 1ns / 1ps

module cvra_div (
	input  logic [cvra_pkg::SUM_W-1:0]    sum,
	input  logic [cvra_pkg::CNT_W-1:0]    cnt,
	output logic [cvra_pkg::SAMPLE_W-1:0] quot
);
	import cvra_pkg::*;

	logic [2*SUM_W-1:0] prod;

	assign prod = sum * DIV3_MUL;

	always_comb begin
		unique case (cnt)
			CNT_W'(1): quot = sum[SAMPLE_W-1:0];
			CNT_W'(2): quot = sum[SAMPLE_W:1];
			CNT_W'(3): quot = prod[DIV3_SHIFT +: SAMPLE_W];
			CNT_W'(4): quot = sum[SAMPLE_W+1:2];
			default:   quot = '0;
		endcase
	end

endmodule

// ===== design/calibration_view_robust_average.sv =====
// throughput: one look per cycle while the output takes words, six stages with valid bits
// stalls from the output collapse bubbles stage by stage, nothing is dropped or repeated
// reset: arst_n clears all valid bits and loads limits 0 / 65535 and deviation 65535
`timescale 1ns / 1ps

module calibration_view_robust_average #(
	parameter int SAMPLES_PER_LOOK = cvra_pkg::SAMPLES_PER_LOOK
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// view_sample_0, view_sample_1, view_sample_2, view_sample_3
	input  logic [cvra_pkg::IN_DATA_W-1:0]  s_tdata,
	// view_kind
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// view_average, in_range_count, kept_count, zero pad
	output logic [cvra_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cvra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cvra_pkg::SAMPLE_W-1:0]   cfg_data
);
	import cvra_pkg::*;

	localparam int USED = (SAMPLES_PER_LOOK < SAMPLE_FIELDS) ? SAMPLES_PER_LOOK : SAMPLE_FIELDS;

	limits_t limits;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	logic [SAMPLE_W-1:0]      smp_s1 [SAMPLE_FIELDS];
	logic [SAMPLE_FIELDS-1:0] pass_s1;
	logic [SAMPLE_W-1:0]      smp_s2 [SAMPLE_FIELDS];
	logic [SAMPLE_FIELDS-1:0] pass_s2;
	logic [SUM_W-1:0]         sum1_s2;
	logic [CNT_W-1:0]         nin_s2;
	logic [SAMPLE_W-1:0]      smp_s3 [SAMPLE_FIELDS];
	logic [SAMPLE_FIELDS-1:0] pass_s3;
	logic [CNT_W-1:0]         nin_s3;
	logic [SAMPLE_W-1:0]      mean1_s3;
	logic [SAMPLE_W-1:0]      smp_s4 [SAMPLE_FIELDS];
	logic [SAMPLE_FIELDS-1:0] keep_s4;
	logic [CNT_W-1:0]         nin_s4;
	logic [SAMPLE_W-1:0]      mean1_s4;
	logic [SUM_W-1:0]         sum2_s5;
	logic [CNT_W-1:0]         nkeep_s5, nin_s5;
	logic [SAMPLE_W-1:0]      mean1_s5;
	logic [SAMPLE_W-1:0]      avg_s6;
	logic [CNT_W-1:0]         nkeep_s6, nin_s6;

	logic [SAMPLE_W-1:0]      lo, hi;
	logic [SAMPLE_FIELDS-1:0] pass_d, keep_d;
	logic [SUM_W-1:0]         sum1_d, sum2_d;
	logic [CNT_W-1:0]         nin_d, nkeep_d;
	logic [SAMPLE_W-1:0]      mean1_d, mean2_d;
	logic [SAMPLE_W-1:0]      diff;

	cvra_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	// a stage moves when it is empty or the next one moves
	assign en6      = !v_s6 || m_tready;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: gross limit check
	always_comb begin
		lo = s_tuser ? limits.bb_low  : limits.space_low;
		hi = s_tuser ? limits.bb_high : limits.space_high;
		for (int i = 0; i < SAMPLE_FIELDS; i++) begin
			pass_d[i] = (i < USED) && (s_tdata[i*SAMPLE_W +: SAMPLE_W] > lo)
				&& (s_tdata[i*SAMPLE_W +: SAMPLE_W] < hi);
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			for (int i = 0; i < SAMPLE_FIELDS; i++) begin
				smp_s1[i] <= s_tdata[i*SAMPLE_W +: SAMPLE_W];
			end
			pass_s1 <= pass_d;
		end
	end

	// stage 2: first sum and count
	always_comb begin
		sum1_d = '0;
		nin_d  = '0;
		for (int i = 0; i < SAMPLE_FIELDS; i++) begin
			if (pass_s1[i]) begin
				sum1_d = sum1_d + SUM_W'(smp_s1[i]);
				nin_d  = nin_d + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			smp_s2  <= smp_s1;
			pass_s2 <= pass_s1;
			sum1_s2 <= sum1_d;
			nin_s2  <= nin_d;
		end
	end

	// stage 3: first mean
	cvra_div u_div1 (
		.sum  (sum1_s2),
		.cnt  (nin_s2),
		.quot (mean1_d)
	);

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			smp_s3   <= smp_s2;
			pass_s3  <= pass_s2;
			nin_s3   <= nin_s2;
			mean1_s3 <= mean1_d;
		end
	end

	// stage 4: deviation check against the first mean
	always_comb begin
		diff = '0;
		for (int i = 0; i < SAMPLE_FIELDS; i++) begin
			diff      = (smp_s3[i] > mean1_s3) ? (smp_s3[i] - mean1_s3) : (mean1_s3 - smp_s3[i]);
			keep_d[i] = pass_s3[i] && (diff <= limits.dev_limit);
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			smp_s4   <= smp_s3;
			keep_s4  <= keep_d;
			nin_s4   <= nin_s3;
			mean1_s4 <= mean1_s3;
		end
	end

	// stage 5: survivor sum and count
	always_comb begin
		sum2_d  = '0;
		nkeep_d = '0;
		for (int i = 0; i < SAMPLE_FIELDS; i++) begin
			if (keep_s4[i]) begin
				sum2_d  = sum2_d + SUM_W'(smp_s4[i]);
				nkeep_d = nkeep_d + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			sum2_s5  <= sum2_d;
			nkeep_s5 <= nkeep_d;
			nin_s5   <= nin_s4;
			mean1_s5 <= mean1_s4;
		end
	end

	// stage 6: survivor mean, first mean stands when nothing survives
	cvra_div u_div2 (
		.sum  (sum2_s5),
		.cnt  (nkeep_s5),
		.quot (mean2_d)
	);

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			avg_s6   <= (nkeep_s5 != '0) ? mean2_d : mean1_s5;
			nin_s6   <= nin_s5;
			nkeep_s6 <= nkeep_s5;
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = {{(OUT_DATA_W - SAMPLE_W - 2*CNT_W){1'b0}}, nkeep_s6, nin_s6, avg_s6};

`ifndef NO_ASSERTIONS
	a_kept_le_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (nkeep_s6 <= nin_s6))
		else $error("kept count exceeds in-range count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && (nin_s6 == '0)) |-> (avg_s6 == '0))
		else $error("nonzero average with no sample in range");

	a_range_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (nin_s2 <= CNT_W'(USED)))
		else $error("in-range count exceeds used samples");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !en5) |=> (v_s5 && $stable(sum2_s5) && $stable(nkeep_s5)))
		else $error("stalled stage lost its word");
`endif

endmodule

// ===== bench/robust_average_checker.sv =====
// scoreboard for the calibration view robust average: predicts every look and checks its word
`timescale 1ns / 1ps

module robust_average_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [cvra_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [cvra_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [cvra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cvra_pkg::SAMPLE_W-1:0]   cfg_data,
	output int                              errors,
	output int                              pending,
	output int                              looks_checked,
	output int                              empty_looks,
	output int                              dropped_looks
);
	import cvra_pkg::*;

	localparam int USED_SAMPLES =
		(SAMPLES_PER_LOOK < SAMPLE_FIELDS) ? SAMPLES_PER_LOOK : SAMPLE_FIELDS;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average;
		logic [CNT_W-1:0]    in_range;
		logic [CNT_W-1:0]    kept;
	} look_result_t;

	limits_t      limits;
	look_result_t awaited_means[$];
	look_result_t want;
	int           fail_count;
	int           checked_count;
	int           empty_count;
	int           dropped_count;

	function automatic look_result_t robust_mean(input logic kind,
			input logic [IN_DATA_W-1:0] look, input limits_t lim);
		logic [SAMPLE_W-1:0]      lo;
		logic [SAMPLE_W-1:0]      hi;
		logic [SAMPLE_W-1:0]      s;
		logic [SAMPLE_W-1:0]      first_mean;
		logic [SAMPLE_W-1:0]      deviation;
		logic [SUM_W-1:0]         sum_in;
		logic [SUM_W-1:0]         sum_kept;
		logic [CNT_W-1:0]         n_in;
		logic [CNT_W-1:0]         n_kept;
		logic [SAMPLE_FIELDS-1:0] passed;
		look_result_t             r;
		lo         = kind ? lim.bb_low : lim.space_low;
		hi         = kind ? lim.bb_high : lim.space_high;
		sum_in     = '0;
		sum_kept   = '0;
		n_in       = '0;
		n_kept     = '0;
		passed     = '0;
		first_mean = '0;
		// gross limit check, both bounds exclusive
		for (int i = 0; i < USED_SAMPLES; i++) begin
			s = look[i*SAMPLE_W +: SAMPLE_W];
			if (s > lo && s < hi) begin
				passed[i] = 1'b1;
				sum_in    = sum_in + SUM_W'(s);
				n_in      = n_in + CNT_W'(1);
			end
		end
		if (n_in != 0) begin
			first_mean = SAMPLE_W'(sum_in / n_in);
			for (int i = 0; i < USED_SAMPLES; i++) begin
				if (passed[i]) begin
					s         = look[i*SAMPLE_W +: SAMPLE_W];
					deviation = (s > first_mean) ? s - first_mean : first_mean - s;
					if (deviation <= lim.dev_limit) begin
						sum_kept = sum_kept + SUM_W'(s);
						n_kept   = n_kept + CNT_W'(1);
					end
				end
			end
		end
		// first mean stands when nothing survives the deviation check
		r.average  = (n_kept != 0) ? SAMPLE_W'(sum_kept / n_kept) : first_mean;
		r.in_range = n_in;
		r.kept     = n_kept;
		return r;
	endfunction

	task automatic check_field(input string field, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			fail_count++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF};
			awaited_means.delete();
			fail_count    = 0;
			checked_count = 0;
			empty_count   = 0;
			dropped_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_SPACE_LOW:  limits.space_low  = cfg_data;
					REG_SPACE_HIGH: limits.space_high = cfg_data;
					REG_BB_LOW:     limits.bb_low     = cfg_data;
					REG_BB_HIGH:    limits.bb_high    = cfg_data;
					REG_DEV_LIMIT:  limits.dev_limit  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				awaited_means = {awaited_means, robust_mean(s_tuser, s_tdata, limits)};
			if (m_tvalid && m_tready) begin
				if (awaited_means.size() == 0) begin
					fail_count++;
					$display("%0t: no word expected, got average %0d in range %0d kept %0d",
						$time, m_tdata[15:0], m_tdata[18:16], m_tdata[21:19]);
				end else begin
					want = awaited_means.pop_front();
					check_field("view_average", 32'(want.average), 32'(m_tdata[15:0]));
					check_field("in_range_count", 32'(want.in_range), 32'(m_tdata[18:16]));
					check_field("kept_count", 32'(want.kept), 32'(m_tdata[21:19]));
					check_field("zero pad", 0, 32'(m_tdata[OUT_DATA_W-1:22]));
					checked_count++;
					if (want.in_range == 0)
						empty_count++;
					else if (want.kept == 0)
						dropped_count++;
				end
			end
		end
		errors        <= fail_count;
		pending       <= awaited_means.size();
		looks_checked <= checked_count;
		empty_looks   <= empty_count;
		dropped_looks <= dropped_count;
	end

endmodule

// ===== bench/calibration_view_robust_average_tb.sv =====
// stimulus, idling and verdict for the calibration view robust average
`timescale 1ns / 1ps

module calibration_view_robust_average_tb;
	import cvra_pkg::*;

	localparam int RESET_CYCLES    = 7;
	localparam int RANDOM_PHASES   = 10;
	localparam int LOOKS_PER_PHASE = 140;
	localparam int STALL_PHASE     = 4;
	localparam int LONG_STALL      = 400;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int DRAIN_CYCLES    = 12;
	localparam logic VIEW_SPACE    = 1'b0;
	localparam logic VIEW_BB       = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [SAMPLE_W-1:0]   cfg_data  = '0;

	int      errors;
	int      pending;
	int      looks_checked;
	int      empty_looks;
	int      dropped_looks;
	int      idle_cycles    = 0;
	int      settings_used  = 0;
	bit      tx_quiet       = 1'b0;
	bit      rx_quiet       = 1'b0;
	bit      hold_output    = 1'b0;
	limits_t limits_now;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	calibration_view_robust_average uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	robust_average_checker looks_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending),
		.looks_checked (looks_checked),
		.empty_looks   (empty_looks),
		.dropped_looks (dropped_looks)
	);

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
	endtask

	task automatic program_limits(input limits_t lim, input bit stray);
		// an index past the register list must leave every limit alone
		if (stray)
			write_reg(REG_UNUSED, SAMPLE_W'($urandom_range(0, 65535)));
		write_reg(REG_SPACE_LOW, lim.space_low);
		write_reg(REG_SPACE_HIGH, lim.space_high);
		write_reg(REG_BB_LOW, lim.bb_low);
		write_reg(REG_BB_HIGH, lim.bb_high);
		write_reg(REG_DEV_LIMIT, lim.dev_limit);
		cfg_valid <= 1'b0;
		limits_now = lim;
		settings_used++;
	endtask

	// drop valid and wait for every look in flight to come out
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic send_look(input logic kind, input logic [IN_DATA_W-1:0] look);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= look;
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	task automatic send_samples(input logic kind, input logic [SAMPLE_W-1:0] a, b, c, d);
		send_look(kind, {d, c, b, a});
	endtask

	function automatic void random_window(output logic [SAMPLE_W-1:0] lo, hi);
		int a;
		int b;
		a = $urandom_range(0, 50000);
		case ($urandom_range(0, 7))
			0: begin
				// empty window: high at or below low
				lo = SAMPLE_W'(a);
				hi = SAMPLE_W'($urandom_range(0, a));
			end
			1: begin
				lo = 16'd0;
				hi = 16'hFFFF;
			end
			default: begin
				lo = SAMPLE_W'(a);
				b  = a + $urandom_range(2, 30000);
				hi = (b > 65535) ? 16'hFFFF : SAMPLE_W'(b);
			end
		endcase
	endfunction

	function automatic limits_t random_limits();
		limits_t lim;
		random_window(lim.space_low, lim.space_high);
		random_window(lim.bb_low, lim.bb_high);
		case ($urandom_range(0, 3))
			0: lim.dev_limit = SAMPLE_W'($urandom_range(0, 8));
			1: lim.dev_limit = SAMPLE_W'($urandom_range(9, 500));
			2: lim.dev_limit = SAMPLE_W'($urandom_range(501, 8000));
			default: lim.dev_limit = $urandom_range(0, 1) ? 16'hFFFF
				: SAMPLE_W'($urandom_range(0, 65535));
		endcase
		return lim;
	endfunction

	// mostly clustered looks around a point inside the window, with outliers,
	// plus fully random looks and looks built from the window edges
	task automatic make_look(output logic kind, output logic [IN_DATA_W-1:0] look);
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		int                  centre;
		int                  spread;
		int                  style;
		int                  v;
		kind   = 1'($urandom_range(0, 1));
		lo     = kind ? limits_now.bb_low : limits_now.space_low;
		hi     = kind ? limits_now.bb_high : limits_now.space_high;
		centre = (int'(lo) + 1 < int'(hi)) ? $urandom_range(int'(lo) + 1, int'(hi) - 1)
			: $urandom_range(0, 65535);
		spread = (limits_now.dev_limit < 10000) ? int'(limits_now.dev_limit) * 2 + 2
			: $urandom_range(1, 20000);
		style  = $urandom_range(0, 9);
		for (int i = 0; i < SAMPLE_FIELDS; i++) begin
			if (style >= 8) begin
				case ($urandom_range(0, 5))
					0: v = int'(lo);
					1: v = int'(lo) + 1;
					2: v = int'(hi) - 1;
					3: v = int'(hi);
					4: v = 0;
					default: v = 65535;
				endcase
			end else if (style >= 6 || $urandom_range(0, 5) == 0) begin
				v = $urandom_range(0, 65535);
			end else begin
				v = centre + int'($urandom_range(0, 2 * spread)) - spread;
			end
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			look[i*SAMPLE_W +: SAMPLE_W] = v[SAMPLE_W-1:0];
		end
	endtask

	// output side: random stalls per word, one long hold-off when asked
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_output) begin
				hold_output = 1'b0;
				gap = LONG_STALL;
			end else begin
				gap = rx_quiet ? 0 : $urandom_range(0, 12);
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("calibration_view_robust_average: mismatch");
				$finish;
			end
		end
	end

	initial begin
		logic                 kind;
		logic [IN_DATA_W-1:0] look;
		limits_t              lim;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		limits_now    = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF};
		settings_used = 1;

		// reset limits: both bounds exclusive, so 0 and 65535 never pass
		send_samples(VIEW_SPACE, 16'd0, 16'd0, 16'd0, 16'd0);
		send_samples(VIEW_BB, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_samples(VIEW_SPACE, 16'd1, 16'd65534, 16'd1, 16'd65534);
		send_samples(VIEW_BB, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
		send_samples(VIEW_SPACE, 16'd0, 16'd5, 16'hFFFF, 16'd7);

		settle();
		program_limits('{16'd100, 16'd60000, 16'd20000, 16'd40000, 16'd300}, 1'b1);
		send_samples(VIEW_SPACE, 16'd1000, 16'd1010, 16'd1020, 16'd5000);
		send_samples(VIEW_SPACE, 16'd1000, 16'd1010, 16'd1020, 16'd1030);
		send_samples(VIEW_SPACE, 16'd1000, 16'd1010, 16'd1020, 16'd1400);
		send_samples(VIEW_SPACE, 16'd100, 16'd60000, 16'd101, 16'd59999);
		send_samples(VIEW_BB, 16'd20001, 16'd39999, 16'd30000, 16'd30000);
		send_samples(VIEW_BB, 16'd30000, 16'd30100, 16'd30200, 16'd31000);
		send_samples(VIEW_SPACE, 16'd500, 16'd600, 16'd700, 16'hFFFF);
		send_samples(VIEW_SPACE, 16'd59999, 16'd59998, 16'd59997, 16'd50);

		// zero deviation, blackbody window with low equal to high
		settle();
		program_limits('{16'd0, 16'hFFFF, 16'd500, 16'd500, 16'd0}, 1'b0);
		send_samples(VIEW_SPACE, 16'd7, 16'd7, 16'd7, 16'd7);
		send_samples(VIEW_SPACE, 16'd10, 16'd20, 16'd10, 16'd20);
		send_samples(VIEW_BB, 16'd499, 16'd500, 16'd501, 16'd0);
		send_samples(VIEW_SPACE, 16'd65534, 16'd65534, 16'd65534, 16'd65533);

		// space window inverted, blackbody wide open
		settle();
		program_limits('{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF}, 1'b0);
		send_samples(VIEW_SPACE, 16'd1, 16'd2, 16'd3, 16'd4);
		send_samples(VIEW_BB, 16'd65534, 16'd65534, 16'd65534, 16'd65534);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			lim = random_limits();
			case (p)
				0: lim = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF};
				1: lim = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0};
				2: begin
					lim.space_low  = 16'hFFFF;
					lim.space_high = 16'd0;
				end
				3: lim.bb_high = lim.bb_low;
				default: ;
			endcase
			program_limits(lim, p == 7);
			tx_quiet    = (p % 3 == 1) || (p == STALL_PHASE);
			rx_quiet    = (p % 4 == 2);
			hold_output = (p == STALL_PHASE);
			repeat (LOOKS_PER_PHASE) begin
				make_look(kind, look);
				send_look(kind, look);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d looks checked under %0d limit settings", looks_checked, settings_used);
		$display("%0d looks had no sample in range, %0d lost every sample to the deviation check",
			empty_looks, dropped_looks);
		if (errors == 0 && pending == 0) begin
			$display("calibration_view_robust_average: match");
		end else begin
			$display("calibration_view_robust_average: mismatch");
		end
		$finish;
	end

endmodule
